[sv/sgb_pkg.sv]
package sgb_pkg;

    // Default build values
    localparam int MAX_WIDTH_DEF      = 2048;
    localparam int RADIUS_DEF         = 3;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int COEF_W     = 17;
    localparam int NCOEF      = 4;
    localparam int CNT_W      = 12;
    localparam int RS_W       = 3;
    localparam int PROD_W     = COEF_W + CH_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int CFG_IDX_W  = 4;
    localparam int FIFO_DEPTH = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [RS_W-1:0]   RS_MAX   = '1;
    localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_HCOEF_CENTER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HCOEF_OFF1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HCOEF_OFF2   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HCOEF_OFF3   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VCOEF_CENTER = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VCOEF_OFF1   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VCOEF_OFF2   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VCOEF_OFF3   = 4'd7;

    typedef logic [NCH-1:0][CH_W-1:0]   pix_t;
    typedef logic [NCH-1:0][PROD_W-1:0] prod_t;

    typedef struct packed {
        logic [CH_W-1:0] pix_c0;
        logic [CH_W-1:0] pix_c1;
        logic [CH_W-1:0] pix_c2;
        logic            end_of_line;
        logic            end_of_frame;
        logic            is_flush;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_c0;
        logic [CH_W-1:0] out_c1;
        logic [CH_W-1:0] out_c2;
        logic            out_end_of_line;
        logic            out_end_of_frame;
        logic            last_in_run;
    } out_t;

    // One column event travelling down the pipeline
    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic             eol;
        logic             eof;
        logic             last;
        logic             flush;
        logic             emit;
        logic [RS_W-1:0]  rs;
    } ev_t;

    typedef enum logic [1:0] {
        WIN_HOLD,
        WIN_FILL,
        WIN_SHIFT,
        WIN_REPEAT
    } win_op_t;

    // Drop fraction bits and clamp at 255
    function automatic logic [CH_W-1:0] norm8(input logic [SUM_W-1:0] s,
                                              input int unsigned sh);
        logic [SUM_W-1:0] q;
        q = s >> sh;
        norm8 = (q > SUM_W'(255)) ? '1 : q[CH_W-1:0];
    endfunction

endpackage

[sv/sgb_tap_cell.sv]
module sgb_tap_cell
    import sgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  pix_t                 d,
    input  logic [COEF_W-1:0]    coef,
    output pix_t                 pix,
    output prod_t                prod
);

    pix_t  pix_reg;
    prod_t prod_reg;

    // Tap sample, loaded from the neighbor or the input
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= d;
        end
    end

    // Weighted tap, one product per channel
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            prod_reg[ch] <= PROD_W'(coef) * PROD_W'(pix_reg[ch]);
        end
    end

    assign pix  = pix_reg;
    assign prod = prod_reg;

endmodule

[sv/sgb_line_store.sv]
module sgb_line_store
    import sgb_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_WIDTH_DEF),
    parameter int DW    = 2 * RADIUS_DEF * NCH * CH_W
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // One write port, one registered read port, old data on collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sgb_out_fifo.sv]
module sgb_out_fifo
    import sgb_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  out_t push_data,
    output logic valid,
    input  logic ready,
    output out_t data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    out_t          buf_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop   = valid && ready;
    assign valid = (count_reg != '0);
    assign data  = buf_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/separable_gaussian_blur_unit.sv]
// Channel  Signals                       Dir  Beat
// pix      pix_valid pix_ready pix       in   one pixel or flush item
// res      res_valid res_ready res       out  one filtered pixel
// cfg      cfg_valid cfg_ready cfg_index in   one coefficient write
//          cfg_data
//
// One pixel per cycle inside a row while queue credits last; a row-end beat
// holds pix_ready low while the window issues the right-border columns.
// An issued column passes the window, product, sum, line store read,
// vertical tap, product, sum and output queue registers in that order.
// Reset clears control state only; line store contents stay undefined.
// A stalled res side drops pix_ready once queued and in-flight results reach 16.
module separable_gaussian_blur_unit
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int RADIUS         = RADIUS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  in_t                  pix,
    output logic                 res_valid,
    input  logic                 res_ready,
    output out_t                 res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam int WIN    = 2 * RADIUS + 1;
    localparam int SLOTS  = 2 * RADIUS;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int DW     = SLOTS * NCH * CH_W;
    localparam int NSTAGE = 7;
    localparam int CRW    = $clog2(FIFO_DEPTH + 1);

    // ---------------- configuration ----------------
    logic [COEF_W-1:0] hcoef_reg [NCOEF];
    logic [COEF_W-1:0] vcoef_reg [NCOEF];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                hcoef_reg[i] <= (i == 0) ? COEF_ONE : '0;
                vcoef_reg[i] <= (i == 0) ? COEF_ONE : '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HCOEF_CENTER: hcoef_reg[0] <= cfg_data;
                REG_HCOEF_OFF1:   hcoef_reg[1] <= cfg_data;
                REG_HCOEF_OFF2:   hcoef_reg[2] <= cfg_data;
                REG_HCOEF_OFF3:   hcoef_reg[3] <= cfg_data;
                REG_VCOEF_CENTER: vcoef_reg[0] <= cfg_data;
                REG_VCOEF_OFF1:   vcoef_reg[1] <= cfg_data;
                REG_VCOEF_OFF2:   vcoef_reg[2] <= cfg_data;
                REG_VCOEF_OFF3:   vcoef_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- front end: column sequencer ----------------
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0] line_width_reg, line_width_next;
    logic [RS_W-1:0]  rows_seen_reg, rows_seen_next;
    logic [RS_W-1:0]  flush_done_reg, flush_done_next;
    logic             draining_reg, draining_next;
    logic             tail_busy_reg, tail_busy_next;
    logic [CNT_W:0]   tail_center_reg, tail_center_next;
    logic [CNT_W-1:0] tail_end_reg, tail_end_next;
    logic [RS_W-1:0]  tail_rs_reg, tail_rs_next;
    logic [CRW-1:0]   credit_reg, credit_next;

    logic             credit_ok;
    logic             accept;
    logic             issue;
    ev_t              ev_new;
    win_op_t          win_op;
    pix_t             pix_in;
    logic             res_pop;

    // front-end scratch
    logic [CNT_W-1:0] c;
    logic [RS_W-1:0]  rs0;
    logic [CNT_W:0]   center;
    logic [CNT_W:0]   c_inc;
    logic             rowend;
    logic             fin;
    logic             row_last;

    assign credit_ok = (credit_reg < CRW'(FIFO_DEPTH));
    assign pix_ready = !tail_busy_reg && credit_ok;
    assign accept    = pix_valid && pix_ready;
    assign pix_in    = {pix.pix_c2, pix.pix_c1, pix.pix_c0};

    always_comb
    begin
        col_cnt_next     = col_cnt_reg;
        line_width_next  = line_width_reg;
        rows_seen_next   = rows_seen_reg;
        flush_done_next  = flush_done_reg;
        draining_next    = draining_reg;
        tail_busy_next   = tail_busy_reg;
        tail_center_next = tail_center_reg;
        tail_end_next    = tail_end_reg;
        tail_rs_next     = tail_rs_reg;
        issue            = 1'b0;
        ev_new           = '0;
        win_op           = WIN_HOLD;
        c                = col_cnt_reg;
        rs0              = rows_seen_reg;
        center           = '0;
        c_inc            = {1'b0, col_cnt_reg} + 1'b1;
        rowend           = 1'b0;
        fin              = 1'b0;
        row_last         = 1'b0;

        if (tail_busy_reg)
        begin
            // right border: repeat last pixel, one column per cycle while credits allow
            if (credit_ok)
            begin
                win_op      = WIN_REPEAT;
                ev_new.col  = tail_center_reg[CNT_W-1:0];
                ev_new.eol  = (tail_center_reg == {1'b0, tail_end_reg});
                ev_new.last = ev_new.eol;
                ev_new.rs   = tail_rs_reg;
                ev_new.emit = (tail_rs_reg >= RS_W'(RADIUS));
                issue       = !tail_center_reg[CNT_W];
                if (tail_center_reg == {1'b0, tail_end_reg})
                begin
                    tail_busy_next = 1'b0;
                end
                else
                begin
                    tail_center_next = tail_center_reg + 1'b1;
                end
            end
        end
        else if (accept)
        begin
            if (pix.is_flush)
            begin
                // flush item replays the stored last row
                if (draining_reg)
                begin
                    rowend       = (c_inc >= {1'b0, line_width_reg});
                    fin          = rowend &&
                                   ({1'b0, flush_done_reg} + 1'b1 >= (RS_W+1)'(RADIUS));
                    issue        = 1'b1;
                    ev_new.col   = c;
                    ev_new.eol   = rowend;
                    ev_new.eof   = fin;
                    ev_new.last  = 1'b1;
                    ev_new.flush = 1'b1;
                    ev_new.rs    = rows_seen_reg;
                    ev_new.emit  = (rows_seen_reg >= RS_W'(RADIUS));
                    if (rowend)
                    begin
                        col_cnt_next    = '0;
                        rows_seen_next  = (rows_seen_reg == RS_MAX) ? rows_seen_reg
                                                                    : rows_seen_reg + 1'b1;
                        flush_done_next = flush_done_reg + 1'b1;
                        if (fin)
                        begin
                            rows_seen_next  = '0;
                            flush_done_next = '0;
                            draining_next   = 1'b0;
                        end
                    end
                    else if (c != CNT_MAX)
                    begin
                        col_cnt_next = c + 1'b1;
                    end
                end
            end
            else
            begin
                // real pixel; a pending drain is abandoned
                if (draining_reg)
                begin
                    c               = '0;
                    rs0             = '0;
                    flush_done_next = '0;
                    draining_next   = 1'b0;
                end
                c_inc       = {1'b0, c} + 1'b1;
                win_op      = (c == '0) ? WIN_FILL : WIN_SHIFT;
                center      = {1'b0, c} - (CNT_W+1)'(RADIUS);
                row_last    = pix.end_of_line || pix.end_of_frame;
                ev_new.col  = center[CNT_W-1:0];
                ev_new.eol  = row_last && (center == {1'b0, c});
                // mid-row beat gives a single column, so it closes its run
                ev_new.last = !row_last || ev_new.eol;
                ev_new.rs   = rs0;
                ev_new.emit = (rs0 >= RS_W'(RADIUS));
                issue       = !center[CNT_W];
                rows_seen_next = rs0;
                if (!row_last)
                begin
                    col_cnt_next = (c == CNT_MAX) ? c : c + 1'b1;
                end
                else
                begin
                    tail_busy_next   = (center != {1'b0, c});
                    tail_center_next = center + 1'b1;
                    tail_end_next    = c;
                    tail_rs_next     = rs0;
                    line_width_next  = c_inc[CNT_W] ? CNT_MAX : c_inc[CNT_W-1:0];
                    rows_seen_next   = (rs0 == RS_MAX) ? rs0 : rs0 + 1'b1;
                    col_cnt_next     = '0;
                    if (pix.end_of_frame)
                    begin
                        draining_next   = 1'b1;
                        flush_done_next = '0;
                    end
                end
            end
        end
    end

    // Output queue credits: one per result in flight or queued
    always_comb
    begin
        credit_next = credit_reg;
        if ((issue && ev_new.emit) && !res_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!(issue && ev_new.emit) && res_pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg     <= '0;
            line_width_reg  <= '0;
            rows_seen_reg   <= '0;
            flush_done_reg  <= '0;
            draining_reg    <= 1'b0;
            tail_busy_reg   <= 1'b0;
            tail_center_reg <= '0;
            tail_end_reg    <= '0;
            tail_rs_reg     <= '0;
            credit_reg      <= '0;
        end
        else
        begin
            col_cnt_reg     <= col_cnt_next;
            line_width_reg  <= line_width_next;
            rows_seen_reg   <= rows_seen_next;
            flush_done_reg  <= flush_done_next;
            draining_reg    <= draining_next;
            tail_busy_reg   <= tail_busy_next;
            tail_center_reg <= tail_center_next;
            tail_end_reg    <= tail_end_next;
            tail_rs_reg     <= tail_rs_next;
            credit_reg      <= credit_next;
        end
    end

    // ---------------- event pipeline ----------------
    ev_t              ev_reg  [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], issue};
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg[0] <= ev_new;
        for (int i = 1; i < NSTAGE; i++)
        begin
            ev_reg[i] <= ev_reg[i-1];
        end
    end

    // ---------------- horizontal window cells ----------------
    pix_t  hwin  [WIN];
    prod_t hprod [WIN];

    for (genvar k = 0; k < WIN; k++)
    begin : g_hcell
        localparam int D = (k < RADIUS) ? RADIUS - k : k - RADIUS;
        pix_t d_k;

        always_comb
        begin
            if (win_op == WIN_FILL)
            begin
                d_k = pix_in;
            end
            else if (k < WIN - 1)
            begin
                d_k = hwin[(k + 1) % WIN];
            end
            else if (win_op == WIN_REPEAT)
            begin
                d_k = hwin[WIN-1];
            end
            else
            begin
                d_k = pix_in;
            end
        end

        sgb_tap_cell u_cell (
            .clk  (clk),
            .en   (win_op != WIN_HOLD),
            .d    (d_k),
            .coef (hcoef_reg[D]),
            .pix  (hwin[k]),
            .prod (hprod[k])
        );
    end

    // Horizontal sum
    logic [NCH-1:0][SUM_W-1:0] hsum_c, hsum_reg;
    pix_t                      hpix_reg;

    always_comb
    begin
        hsum_c = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                hsum_c[ch] = hsum_c[ch] + SUM_W'(hprod[k][ch]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hsum_reg <= hsum_c;
        for (int ch = 0; ch < NCH; ch++)
        begin
            hpix_reg[ch] <= norm8(hsum_reg[ch], COEF_FRAC_BITS);
        end
    end

    // ---------------- line store ----------------
    logic [SLOTS-1:0][NCH*CH_W-1:0] rdata, old_row, new_row, wr_data_reg;
    logic                           wr_v_reg;
    logic [CNT_W-1:0]               wr_col_reg;
    logic                           inr3;
    logic                           wr_en;
    pix_t                           cur;
    pix_t                           vtap [WIN];
    logic [RS_W-1:0]                age;

    assign inr3  = ({1'b0, ev_reg[3].col} < (CNT_W+1)'(MAX_WIDTH));
    assign wr_en = vld_reg[3] && inr3;

    sgb_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ev_reg[3].col[AW-1:0]),
        .wr_data (new_row),
        .rd_addr (ev_reg[2].col[AW-1:0]),
        .rd_data (rdata)
    );

    // Vertical taps with forwarding of last cycle's write
    always_comb
    begin
        old_row = (wr_v_reg && (wr_col_reg == ev_reg[3].col)) ? wr_data_reg : rdata;
        if (ev_reg[3].flush)
        begin
            cur = inr3 ? old_row[0] : '0;
        end
        else
        begin
            cur = hpix_reg;
        end
        vtap[0] = cur;
        age     = '0;
        for (int a = 1; a < WIN; a++)
        begin
            age     = (RS_W'(a) > ev_reg[3].rs) ? ev_reg[3].rs : RS_W'(a);
            vtap[a] = (age == '0) ? cur : '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                if (inr3 && (age == RS_W'(s + 1)))
                begin
                    vtap[a] = old_row[s];
                end
            end
        end
        new_row[0] = cur;
        for (int s = 1; s < SLOTS; s++)
        begin
            new_row[s] = old_row[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_v_reg <= 1'b0;
        end
        else
        begin
            wr_v_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_col_reg  <= ev_reg[3].col;
        wr_data_reg <= new_row;
    end

    // ---------------- vertical cells ----------------
    prod_t vprod [WIN];
    pix_t  vpix  [WIN];

    for (genvar k = 0; k < WIN; k++)
    begin : g_vcell
        localparam int D = (k < RADIUS) ? RADIUS - k : k - RADIUS;

        sgb_tap_cell u_cell (
            .clk  (clk),
            .en   (1'b1),
            .d    (vtap[k]),
            .coef (vcoef_reg[D]),
            .pix  (vpix[k]),
            .prod (vprod[k])
        );
    end

    logic [NCH-1:0][SUM_W-1:0] vsum_c, vsum_reg;

    always_comb
    begin
        vsum_c = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                vsum_c[ch] = vsum_c[ch] + SUM_W'(vprod[k][ch]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vsum_reg <= vsum_c;
    end

    // ---------------- result queue ----------------
    out_t push_data;
    logic push;

    assign push = vld_reg[6] && ev_reg[6].emit;

    always_comb
    begin
        push_data.out_c0           = norm8(vsum_reg[0], COEF_FRAC_BITS);
        push_data.out_c1           = norm8(vsum_reg[1], COEF_FRAC_BITS);
        push_data.out_c2           = norm8(vsum_reg[2], COEF_FRAC_BITS);
        push_data.out_end_of_line  = ev_reg[6].eol;
        push_data.out_end_of_frame = ev_reg[6].eof;
        push_data.last_in_run      = ev_reg[6].last;
    end

    sgb_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .valid     (res_valid),
        .ready     (res_ready),
        .data      (res)
    );

    assign res_pop = res_valid && res_ready;

endmodule

[sv/sgb_checker.sv]
module sgb_checker
    import sgb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic pix_valid,
    input logic pix_ready,
    input in_t  pix,
    input logic res_valid,
    input logic res_ready,
    input out_t res
);

    // A stalled result beat holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    // Frame end only on the closing column of a run
    a_eof_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.out_end_of_frame |-> res.out_end_of_line && res.last_in_run)
        else $error("frame end without line end or run end");

    // Row end is always the last result of its input beat
    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.out_end_of_line |-> res.last_in_run)
        else $error("line end not last in run");

    // A real row-end beat starts the right-border tail
    a_tail_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && !pix.is_flush && (pix.end_of_line || pix.end_of_frame)
        |=> !pix_ready)
        else $error("input taken during right-border tail");

endmodule

bind separable_gaussian_blur_unit sgb_checker u_sgb_checker (.*);
